>>> hw/rtl/wps_pkg.sv
// Shared types and constants for the WAV PCM stream parser.
// Depends on nothing; every other file imports it.
`default_nettype none

package wps_pkg;

  localparam int unsigned MinFileBytes = 44;

  localparam logic [31:0] ID_RIFF = 32'h4646_4952;
  localparam logic [31:0] ID_WAVE = 32'h4556_4157;
  localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
  localparam logic [31:0] ID_DATA = 32'h6174_6164;

  localparam logic [15:0] FMT_PCM    = 16'd1;
  localparam logic [15:0] CHANS_MONO = 16'd1;
  localparam logic [31:0] WANT_RATE  = 32'd44100;
  localparam logic [15:0] WANT_BITS  = 16'd16;
  localparam logic [31:0] FMT_BODY_BYTES = 32'd16;

  // result kinds
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_ERROR  = 2'd1;
  localparam logic [1:0] KIND_EMPTY  = 2'd2;

  // error codes
  localparam logic [3:0] ERR_SMALL     = 4'd0;
  localparam logic [3:0] ERR_SIGNATURE = 4'd1;
  localparam logic [3:0] ERR_NOT_PCM   = 4'd2;
  localparam logic [3:0] ERR_NOT_MONO  = 4'd3;
  localparam logic [3:0] ERR_RATE      = 4'd4;
  localparam logic [3:0] ERR_BITS      = 4'd5;
  localparam logic [3:0] ERR_NO_FMT    = 4'd6;
  localparam logic [3:0] ERR_NO_DATA   = 4'd7;
  localparam logic [3:0] ERR_TRUNCATED = 4'd8;
  localparam logic [3:0] ERR_NONE      = 4'd0;

  typedef enum logic [2:0] {
    PH_SIG,
    PH_HDR,
    PH_FMT,
    PH_SKIP,
    PH_DATA,
    PH_ABSORB
  } phase_t;

  // one classified byte, front to back
  typedef struct packed {
    logic [7:0]  byte_val;
    logic        too_small;  // first byte of a file shorter than the minimum
    logic        is_final;   // last byte of the file
    logic [1:0]  lane;       // byte position modulo four
    logic        pos_is3;
    logic        pos_ge11;
    logic [31:0] left;       // bytes of the file still to come after this one
  } item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] sample;
    logic [3:0]         code;
    logic               last;
  } res_t;

endpackage

`default_nettype wire

>>> hw/rtl/wps_front.sv
// Front end: takes file bytes, keeps the byte position and the file length
// register, and tags each byte with its place in the file. Uses wps_pkg.
`default_nettype none

module wps_front
  import wps_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [7:0]  in_byte,
  output item_t            item
);

  logic [31:0] file_length;
  logic [31:0] pos;
  logic [31:0] pos1;   // pos + 1
  logic [32:0] diff;
  logic        final_byte;
  logic        accept;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  assign diff       = {1'b0, file_length} - {1'b0, pos1};
  assign final_byte = diff[32] || (diff[31:0] == 32'd0);

  always_comb begin
    item.byte_val  = in_byte;
    item.too_small = (pos == 32'd0) && (file_length < 32'(MinFileBytes));
    item.is_final  = final_byte;
    item.lane      = pos[1:0];
    item.pos_is3   = (pos == 32'd3);
    item.pos_ge11  = (pos >= 32'd11);
    item.left      = final_byte ? 32'd0 : diff[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      file_length <= 32'd0;
      pos         <= 32'd0;
      pos1        <= 32'd1;
    end else begin
      if (cfg_valid && cfg_ready) begin
        file_length <= cfg_data;
      end
      if (accept) begin
        if (final_byte) begin
          pos  <= 32'd0;
          pos1 <= 32'd1;
        end else begin
          pos  <= pos1;
          pos1 <= pos1 + 32'd1;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/wps_queue.sv
// Two-entry queue of tagged bytes between the front end and the parser.
// Uses item_t from wps_pkg.
`default_nettype none

module wps_queue
  import wps_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  item_t     push_item,
  output logic      not_full,
  input  wire logic pop,
  output logic      not_empty,
  output item_t     head
);

  item_t       entries [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign not_full  = (count != 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/wps_back.sv
// Parser back end: walks the RIFF chunks one tagged byte per cycle while the
// result stage is not stalled, and drives the registered result stage. Uses wps_pkg.
`default_nettype none

module wps_back
  import wps_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic item_valid,
  input  item_t     item,
  output logic      item_pop,
  output logic      res_valid,
  input  wire logic res_ready,
  output res_t      res
);

  phase_t      phase, phase_next;
  logic [3:0]  fshift, fshift_next;
  logic [31:0] crem, crem_next;
  logic        fseen, fseen_next;
  logic [63:0] ffields, ffields_next;
  logic [7:0]  low_byte, low_next;
  logic [30:0] sleft, sleft_next;

  res_t        res_next;
  logic        emit;
  logic        step;

  assign step     = item_valid && (!res_valid || res_ready);
  assign item_pop = step;

  always_comb begin
    logic [7:0]  b;
    logic [2:0]  hk;
    logic [15:0] bits;
    logic [3:0]  fcode;

    b    = item.byte_val;
    hk   = fshift[2:0];
    bits = {b, low_byte};
    fcode = ERR_NONE;

    phase_next   = phase;
    fshift_next  = fshift;
    crem_next    = crem;
    fseen_next   = fseen;
    ffields_next = ffields;
    low_next     = low_byte;
    sleft_next   = sleft;
    res_next     = '0;
    emit         = 1'b0;

    if (item.too_small) begin
      emit          = 1'b1;
      res_next.kind = KIND_ERROR;
      res_next.code = ERR_SMALL;
      res_next.last = 1'b1;
      phase_next    = PH_ABSORB;
    end else begin
      case (phase)
        PH_SIG: begin
          if (item.lane == 2'd0) begin
            ffields_next[31:0] = '0;
          end
          ffields_next[{item.lane, 3'b000} +: 8] = b;
          if (item.pos_is3 && (ffields_next[31:0] != ID_RIFF)) begin
            ffields_next[32] = 1'b1;
          end
          if (item.pos_ge11) begin
            if (ffields_next[32] || (ffields_next[31:0] != ID_WAVE)) begin
              emit          = 1'b1;
              res_next.kind = KIND_ERROR;
              res_next.code = ERR_SIGNATURE;
              res_next.last = 1'b1;
              phase_next    = PH_ABSORB;
            end else begin
              phase_next   = PH_HDR;
              fshift_next  = 4'd0;
              ffields_next = '0;
            end
          end
        end
        PH_HDR: begin
          if (!hk[2]) begin
            if (hk == 3'd0) begin
              ffields_next = '0;
            end
            ffields_next[{hk[1:0], 3'b000} +: 8] = b;
          end else begin
            if (hk == 3'd4) begin
              crem_next = '0;
            end
            crem_next[{hk[1:0], 3'b000} +: 8] = b;
          end
          fshift_next = {1'b0, hk} + 4'd1;
          if (hk == 3'd7) begin
            fshift_next = 4'd0;
            if (ffields_next[31:0] == ID_FMT) begin
              fseen_next   = 1'b1;
              ffields_next = '0;
              phase_next   = PH_FMT;
            end else if (ffields_next[31:0] == ID_DATA) begin
              if (!fseen) begin
                emit          = 1'b1;
                res_next.kind = KIND_ERROR;
                res_next.code = ERR_NO_FMT;
                res_next.last = 1'b1;
                phase_next    = PH_ABSORB;
              end else if (crem_next > item.left) begin
                emit          = 1'b1;
                res_next.kind = KIND_ERROR;
                res_next.code = ERR_TRUNCATED;
                res_next.last = 1'b1;
                phase_next    = PH_ABSORB;
              end else begin
                sleft_next = crem_next[31:1];
                if (crem_next[31:1] == 31'd0) begin
                  emit          = 1'b1;
                  res_next.kind = KIND_EMPTY;
                  res_next.last = 1'b1;
                  phase_next    = PH_ABSORB;
                end else begin
                  phase_next = PH_DATA;
                end
              end
            end else begin
              phase_next = (crem_next == 32'd0) ? PH_HDR : PH_SKIP;
            end
          end
        end
        PH_FMT: begin
          if (!fshift[3]) begin
            ffields_next[{fshift[2:0], 3'b000} +: 8] = b;
          end else if (fshift == 4'd14) begin
            low_next = b;
          end
          fshift_next = fshift + 4'd1;
          if (fshift == 4'd15) begin
            fshift_next = 4'd0;
            low_next    = 8'd0;
            if (ffields[15:0] != FMT_PCM) begin
              fcode = ERR_NOT_PCM;
            end else if (ffields[31:16] != CHANS_MONO) begin
              fcode = ERR_NOT_MONO;
            end else if (ffields[63:32] != WANT_RATE) begin
              fcode = ERR_RATE;
            end else if (bits != WANT_BITS) begin
              fcode = ERR_BITS;
            end
            if (fcode != ERR_NONE) begin
              emit          = 1'b1;
              res_next.kind = KIND_ERROR;
              res_next.code = fcode;
              res_next.last = 1'b1;
              phase_next    = PH_ABSORB;
            end else begin
              crem_next  = (crem > FMT_BODY_BYTES) ? crem - FMT_BODY_BYTES : 32'd0;
              phase_next = (crem_next == 32'd0) ? PH_HDR : PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          if (crem != 32'd0) begin
            crem_next = crem - 32'd1;
          end
          if (crem_next == 32'd0) begin
            fshift_next = 4'd0;
            phase_next  = PH_HDR;
          end
        end
        PH_DATA: begin
          if (fshift == 4'd0) begin
            low_next    = b;
            fshift_next = 4'd1;
          end else begin
            fshift_next     = 4'd0;
            emit            = 1'b1;
            res_next.kind   = KIND_SAMPLE;
            res_next.sample = {b, low_byte};
            if (sleft != 31'd0) begin
              sleft_next = sleft - 31'd1;
            end
            if (sleft_next == 31'd0) begin
              res_next.last = 1'b1;
              phase_next    = PH_ABSORB;
            end
          end
        end
        PH_ABSORB: begin
          phase_next = PH_ABSORB;
        end
        default: begin
          phase_next = PH_ABSORB;
        end
      endcase
    end

    if (item.is_final) begin
      if (!emit && (phase_next != PH_ABSORB)) begin
        emit            = 1'b1;
        res_next.kind   = KIND_ERROR;
        res_next.last   = 1'b1;
        res_next.sample = '0;
        if ((phase_next == PH_FMT) || (phase_next == PH_DATA)) begin
          res_next.code = ERR_TRUNCATED;
        end else if (phase_next == PH_SIG) begin
          res_next.code = ERR_SMALL;
        end else begin
          res_next.code = fseen_next ? ERR_NO_DATA : ERR_NO_FMT;
        end
      end
      phase_next   = PH_SIG;
      fshift_next  = '0;
      crem_next    = '0;
      fseen_next   = 1'b0;
      ffields_next = '0;
      low_next     = '0;
      sleft_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_SIG;
      fshift   <= '0;
      crem     <= '0;
      fseen    <= 1'b0;
      ffields  <= '0;
      low_byte <= '0;
      sleft    <= '0;
    end else if (step) begin
      phase    <= phase_next;
      fshift   <= fshift_next;
      crem     <= crem_next;
      fseen    <= fseen_next;
      ffields  <= ffields_next;
      low_byte <= low_next;
      sleft    <= sleft_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step) begin
      res_valid <= emit;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/wav_pcm_stream_parser.sv
// WAV PCM stream parser. Feed a RIFF/WAVE file one byte per beat on the slave
// stream after writing its byte length on the configuration channel. The block
// accepts one byte every cycle while its queue has room, and gives at most one
// result beat per byte: a signed 16-bit mono sample, an error code, or a
// "finished with no samples" marker, with tlast high on the final result of
// the file. A byte is held in the queue, then its result beat in the
// registered result stage when that stage is free; the two-entry queue
// between the byte classifier and the chunk parser, and the registered result
// stage, let either side stall on its own while sustained throughput stays
// one byte per cycle. Files under 44 bytes, a bad signature, a format other
// than PCM/mono/44100 Hz/16 bit, a missing fmt or data chunk and truncation
// are reported as errors; bytes after an error or after the data chunk are
// absorbed up to the end of the file, and the next byte starts a new file
// of the same length. Depends on wps_pkg, wps_front, wps_queue and wps_back.
`default_nettype none

module wav_pcm_stream_parser
  import wps_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration: file length in bytes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data,
  // file bytes in
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] file_byte
  // results out
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [15:0] sample, [19:16] error_code, [23:20] zero
  output logic [1:0]       m_tuser,   // [1:0] kind
  output logic             m_tlast
);

  item_t front_item;
  item_t head_item;
  logic  q_not_full;
  logic  q_not_empty;
  logic  q_pop;
  res_t  res;

  // Hold the byte stream back only when the queue is full.
  assign s_tready = q_not_full;

  wps_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_byte   (s_tdata),
    .item      (front_item)
  );

  wps_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s_tvalid && s_tready),
    .push_item (front_item),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (head_item)
  );

  // Advance the parser one byte whenever the queue holds one and the result stage can take a beat.
  wps_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (q_not_empty),
    .item       (head_item),
    .item_pop   (q_pop),
    .res_valid  (m_tvalid),
    .res_ready  (m_tready),
    .res        (res)
  );

  assign m_tdata = {4'd0, res.code, res.sample};
  assign m_tuser = res.kind;
  assign m_tlast = res.last;

endmodule

`default_nettype wire

>>> hw/rtl/wps_checker.sv
// Port-level checks for the WAV PCM stream parser, bound to the top level.
// Depends on wps_pkg and wav_pcm_stream_parser.
`default_nettype none

module wps_checker
  import wps_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [23:0] m_tdata,
  input wire logic [1:0]  m_tuser,
  input wire logic        m_tlast
);

  a_error_is_last : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == KIND_ERROR)) |-> m_tlast)
    else $error("error beat without tlast");

  a_empty_clean : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == KIND_EMPTY)) |-> (m_tlast && (m_tdata == 24'd0)))
    else $error("empty-file beat carries data or lacks tlast");

  a_sample_no_code : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == KIND_SAMPLE)) |-> (m_tdata[23:16] == 8'd0))
    else $error("sample beat carries an error code");

  a_no_result_from_nothing : assert property (@(posedge clk) disable iff (rst)
    ($rose(m_tvalid) && $past(!m_tvalid) && $past(!s_tvalid, 2) && $past(!s_tvalid, 1)
     && $past(!m_tvalid, 2) && $past(s_tready, 2) && $past(s_tready, 3)
     && $past(!s_tvalid, 3)) |-> 1'b0)
    else $error("result beat without a recent input byte");

  a_stall_holds : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                 && $stable(m_tlast)))
    else $error("result beat changed while stalled");

endmodule

bind wav_pcm_stream_parser wps_checker u_wps_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire

>>> tb/wps_stream_checker.sv
// Checker for the WAV PCM stream parser: watches the configuration, byte and
// result channels, predicts every result beat and compares it field by field.
// Depends on wps_pkg for the phase, kind and error code names and the result type.
module wps_stream_checker
  import wps_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [31:0] cfg_data,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [7:0]  s_tdata,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [23:0] m_tdata,
  input  wire logic [1:0]  m_tuser,
  input  wire logic        m_tlast,
  output int unsigned      pending,
  output int unsigned      failures
);

  // parser state, kept apart from the block
  logic [31:0] file_len;
  logic [31:0] byte_pos;
  logic [31:0] field_cnt;
  logic [31:0] chunk_left;
  phase_t      phase;
  logic        fmt_seen;
  logic [63:0] fmt_words;
  logic [7:0]  low_byte;
  logic [30:0] samples_left;

  res_t        parsed_results[$];
  res_t        oldest;
  int unsigned fault_count;

  task automatic clear_file;
    byte_pos     = '0;
    phase        = PH_SIG;
    field_cnt    = '0;
    chunk_left   = '0;
    fmt_seen     = 1'b0;
    fmt_words    = '0;
    low_byte     = '0;
    samples_left = '0;
  endtask

  // advance the parser by one file byte; queue the result it gives, if any
  task automatic parse_byte(input logic [7:0] b);
    logic [31:0] pos;
    logic [31:0] left;
    logic [31:0] rate;
    logic [15:0] fmt_tag;
    logic [15:0] chans;
    logic [15:0] bits;
    logic [3:0]  fault;
    logic [2:0]  k8;
    logic [3:0]  k16;
    logic [1:0]  lane;
    logic        closing;
    logic        emit;
    logic        bad;
    res_t        r;
    pos     = byte_pos;
    closing = ({1'b0, pos} + 33'd1) >= {1'b0, file_len};
    r       = '0;
    emit    = 1'b0;
    if (pos == 0 && file_len < MinFileBytes) begin
      r.kind = KIND_ERROR;
      r.code = ERR_SMALL;
      r.last = 1'b1;
      emit   = 1'b1;
      phase  = PH_ABSORB;
    end else begin
      case (phase)
        PH_SIG: begin
          lane = pos[1:0];
          if (lane == 0) fmt_words[31:0] = '0;
          fmt_words = fmt_words | (64'(b) << (8 * lane));
          // remember a bad RIFF word in bit 32 until the WAVE word is in
          if (pos == 3 && fmt_words[31:0] != ID_RIFF) fmt_words[32] = 1'b1;
          if (pos >= 11) begin
            if (fmt_words[63:32] != 0 || fmt_words[31:0] != ID_WAVE) begin
              r.kind = KIND_ERROR;
              r.code = ERR_SIGNATURE;
              r.last = 1'b1;
              emit   = 1'b1;
              phase  = PH_ABSORB;
            end else begin
              phase     = PH_HDR;
              field_cnt = '0;
              fmt_words = '0;
            end
          end
        end
        PH_HDR: begin
          k8 = field_cnt[2:0];
          if (k8 < 4) begin
            if (k8 == 0) fmt_words = '0;
            fmt_words = fmt_words | (64'(b) << (8 * k8));
          end else begin
            if (k8 == 4) chunk_left = '0;
            chunk_left = chunk_left | (32'(b) << (8 * (k8 - 4)));
          end
          field_cnt = 32'(k8) + 32'd1;
          if (k8 == 7) begin
            field_cnt = '0;
            if (fmt_words[31:0] == ID_FMT) begin
              fmt_seen  = 1'b1;
              fmt_words = '0;
              phase     = PH_FMT;
            end else if (fmt_words[31:0] == ID_DATA) begin
              left = (file_len > pos + 32'd1) ? file_len - (pos + 32'd1) : 32'd0;
              if (!fmt_seen) begin
                r.kind = KIND_ERROR;
                r.code = ERR_NO_FMT;
                r.last = 1'b1;
                emit   = 1'b1;
                phase  = PH_ABSORB;
              end else if (chunk_left > left) begin
                r.kind = KIND_ERROR;
                r.code = ERR_TRUNCATED;
                r.last = 1'b1;
                emit   = 1'b1;
                phase  = PH_ABSORB;
              end else begin
                samples_left = chunk_left[31:1];
                if (samples_left == 0) begin
                  r.kind = KIND_EMPTY;
                  r.last = 1'b1;
                  emit   = 1'b1;
                  phase  = PH_ABSORB;
                end else begin
                  phase = PH_DATA;
                end
              end
            end else begin
              phase = (chunk_left == 0) ? PH_HDR : PH_SKIP;
            end
          end
        end
        PH_FMT: begin
          k16 = field_cnt[3:0];
          if (k16 < 8) fmt_words = fmt_words | (64'(b) << (8 * k16));
          else if (k16 == 14) low_byte = b;
          field_cnt = 32'(k16) + 32'd1;
          if (k16 == 15) begin
            fmt_tag   = fmt_words[15:0];
            chans     = fmt_words[31:16];
            rate      = fmt_words[63:32];
            bits      = {b, low_byte};
            field_cnt = '0;
            low_byte  = '0;
            bad       = 1'b1;
            fault     = ERR_NONE;
            // the order of these tests sets which fault is reported
            if (fmt_tag != FMT_PCM) fault = ERR_NOT_PCM;
            else if (chans != CHANS_MONO) fault = ERR_NOT_MONO;
            else if (rate != WANT_RATE) fault = ERR_RATE;
            else if (bits != WANT_BITS) fault = ERR_BITS;
            else bad = 1'b0;
            if (bad) begin
              r.kind = KIND_ERROR;
              r.code = fault;
              r.last = 1'b1;
              emit   = 1'b1;
              phase  = PH_ABSORB;
            end else begin
              chunk_left = (chunk_left > FMT_BODY_BYTES) ? chunk_left - FMT_BODY_BYTES : '0;
              phase      = (chunk_left == 0) ? PH_HDR : PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          if (chunk_left > 0) chunk_left = chunk_left - 32'd1;
          if (chunk_left == 0) begin
            field_cnt = '0;
            phase     = PH_HDR;
          end
        end
        PH_DATA: begin
          if (field_cnt == 0) begin
            low_byte  = b;
            field_cnt = 32'd1;
          end else begin
            field_cnt = '0;
            r.sample  = {b, low_byte};
            r.kind    = KIND_SAMPLE;
            emit      = 1'b1;
            if (samples_left > 0) samples_left = samples_left - 31'd1;
            if (samples_left == 0) begin
              r.last = 1'b1;
              phase  = PH_ABSORB;
            end
          end
        end
        default: begin
        end
      endcase
    end

    byte_pos = pos + 32'd1;

    if (closing) begin
      // the file ran out with nothing said yet: report why
      if (!emit && phase != PH_ABSORB) begin
        r.kind   = KIND_ERROR;
        r.last   = 1'b1;
        r.sample = '0;
        emit     = 1'b1;
        if (phase == PH_FMT || phase == PH_DATA) r.code = ERR_TRUNCATED;
        else if (phase == PH_SIG) r.code = ERR_SMALL;
        else r.code = fmt_seen ? ERR_NO_DATA : ERR_NO_FMT;
      end
      clear_file();
    end

    if (emit) parsed_results.push_back(r);
  endtask

  task automatic compare_field(input string field, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      fault_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      file_len = '0;
      clear_file();
      parsed_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) file_len = cfg_data;
      if (s_tvalid && s_tready) parse_byte(s_tdata);
      if (m_tvalid && m_tready) begin
        if (parsed_results.size() == 0) begin
          $error("result beat with nothing due: kind %0d, data %h, last %0d",
                 m_tuser, m_tdata, m_tlast);
          fault_count++;
        end else begin
          oldest = parsed_results.pop_front();
          compare_field("kind", int'(oldest.kind), int'(m_tuser));
          compare_field("sample", int'($signed(oldest.sample)), int'($signed(m_tdata[15:0])));
          compare_field("error_code", int'(oldest.code), int'(m_tdata[19:16]));
          compare_field("pad", 0, int'(m_tdata[23:20]));
          compare_field("last", int'(oldest.last), int'(m_tlast));
        end
      end
    end
    pending  <= parsed_results.size();
    failures <= fault_count;
  end

endmodule

>>> tb/wav_pcm_stream_parser_tb.sv
// Top of the WAV PCM stream parser testbench: clock, reset, file stimulus and
// pacing, and the verdict. Depends on wps_pkg, the parser and wps_stream_checker.
module wav_pcm_stream_parser_tb;
  import wps_pkg::*;

  localparam int unsigned ByteTarget    = 1750;
  localparam int unsigned CycleLimit    = 400000;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned ScenarioCount = 16;
  localparam logic [31:0] HugeLength    = 32'hFFFF_FFFF;

  // shapes of file the stimulus can build
  typedef enum int unsigned {
    CLEAN_FILE,
    SHORT_LENGTH,
    NOISE,
    BAD_RIFF,
    BAD_WAVE,
    NOT_PCM,
    NOT_MONO,
    BAD_RATE,
    BAD_BITS,
    LONG_FMT,
    SHORT_FMT,
    DATA_FIRST,
    NO_DATA,
    OVERSIZE_DATA,
    EMPTY_DATA,
    CUT_SHORT
  } scenario_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data  = '0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = '0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [23:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  int unsigned due_count;
  int unsigned fault_total;
  int unsigned cycle_count = 0;
  int unsigned gap_pct     = 0;
  int unsigned stall_pct   = 0;
  int unsigned sent_bytes  = 0;

  logic [7:0]  wav_image[$];

  wav_pcm_stream_parser dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  wps_stream_checker stream_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .pending   (due_count),
    .failures  (fault_total)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // guard against a hung handshake
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("wav_pcm_stream_parser verification failed");
      $finish;
    end
  end

  // result side: stall at the rate of the current pacing phase
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // offer one file byte, idling first at random, and hold it until taken;
  // valid stays high afterwards so back-to-back beats need no second write
  task automatic send_byte(input logic [7:0] value);
    while ($urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    do @(posedge clk); while (!s_tready);
    sent_bytes++;
  endtask

  // drop valid, let every due result drain, then allow the pipeline to empty
  // of bytes that give no result
  task automatic settle;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_length(input logic [31:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic void put_le(input logic [31:0] value, input int unsigned count);
    int unsigned i;
    for (i = 0; i < count; i++) wav_image.push_back(value[8 * i +: 8]);
  endfunction

  // bias payload bytes towards the sample extremes
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] flip_bit(input logic [31:0] value, input int unsigned width);
    return value ^ (32'd1 << $urandom_range(width - 1));
  endfunction

  // a chunk the parser should step over, never fmt or data
  function automatic void put_junk(input int unsigned size);
    logic [31:0] id;
    int unsigned i;
    do id = $urandom; while (id == ID_FMT || id == ID_DATA);
    put_le(id, 4);
    put_le(size, 4);
    for (i = 0; i < size; i++) wav_image.push_back(pick_byte());
  endfunction

  function automatic void put_data(input logic [31:0] declared, input int unsigned size);
    int unsigned i;
    put_le(ID_DATA, 4);
    put_le(declared, 4);
    for (i = 0; i < size; i++) wav_image.push_back(pick_byte());
  endfunction

  // build one file image of the given shape and choose how many bytes of it
  // make up the file; sweep pins the too-short length to its upper extreme
  task automatic build_wav(input scenario_t sc, input bit sweep,
                           output int unsigned stream_len);
    logic [31:0] riff_id;
    logic [31:0] wave_id;
    logic [31:0] rate;
    logic [31:0] fmt_size;
    logic [31:0] data_declared;
    logic [15:0] fmt_tag;
    logic [15:0] chans;
    logic [15:0] bits;
    int unsigned data_size;
    int unsigned trail;
    int unsigned i;
    bit          with_fmt;
    bit          with_data;
    bit          data_first;
    bit          lead_junk;
    bit          mid_junk;
    riff_id    = ID_RIFF;
    wave_id    = ID_WAVE;
    rate       = WANT_RATE;
    fmt_size   = FMT_BODY_BYTES;
    fmt_tag    = FMT_PCM;
    chans      = CHANS_MONO;
    bits       = WANT_BITS;
    with_fmt   = 1'b1;
    with_data  = 1'b1;
    data_first = 1'b0;
    lead_junk  = ($urandom_range(3) == 0);
    mid_junk   = ($urandom_range(3) == 0);
    // mostly short data, now and then a long run of samples
    data_size  = ($urandom_range(15) == 0) ? $urandom_range(41, 300) : $urandom_range(2, 40);
    trail      = ($urandom_range(3) == 0) ? $urandom_range(1, 6) : 0;
    case (sc)
      BAD_RIFF: riff_id = flip_bit(riff_id, 32);
      BAD_WAVE: begin
        wave_id = flip_bit(wave_id, 32);
        if ($urandom_range(1)) riff_id = flip_bit(riff_id, 32);
      end
      // corrupt later fields too at times: the first fault in order must win
      NOT_PCM: begin
        fmt_tag = 16'(flip_bit(32'(fmt_tag), 16));
        if ($urandom_range(1)) chans = 16'(flip_bit(32'(chans), 16));
      end
      NOT_MONO: begin
        chans = 16'(flip_bit(32'(chans), 16));
        if ($urandom_range(1)) rate = flip_bit(rate, 32);
      end
      BAD_RATE: begin
        rate = flip_bit(rate, 32);
        if ($urandom_range(1)) bits = 16'(flip_bit(32'(bits), 16));
      end
      BAD_BITS:   bits = 16'(flip_bit(32'(bits), 16));
      LONG_FMT:   fmt_size = $urandom_range(17, 24);
      SHORT_FMT:  fmt_size = $urandom_range(0, 15);
      DATA_FIRST: data_first = 1'b1;
      NO_DATA: begin
        with_data = 1'b0;
        with_fmt  = $urandom_range(1);
      end
      EMPTY_DATA: data_size = $urandom_range(1);
      CUT_SHORT:  lead_junk = 1'b1;
      default: begin
      end
    endcase
    data_declared = data_size;
    if (sc == OVERSIZE_DATA) begin
      data_declared = $urandom_range(1) ? HugeLength : data_size + trail + $urandom_range(1, 64);
    end

    wav_image.delete();
    if (sc == NOISE) begin
      stream_len = $urandom_range(44, 90);
      for (i = 0; i < stream_len; i++) wav_image.push_back(8'($urandom));
    end else begin
      put_le(riff_id, 4);
      put_le($urandom, 4);
      put_le(wave_id, 4);
      if (lead_junk) put_junk(sc == CUT_SHORT ? $urandom_range(8, 20) : $urandom_range(0, 9));
      if (data_first) put_data(data_declared, data_size);
      if (with_fmt) begin
        put_le(ID_FMT, 4);
        put_le(fmt_size, 4);
        put_le(32'(fmt_tag), 2);
        put_le(32'(chans), 2);
        put_le(rate, 4);
        put_le($urandom, 4);
        put_le($urandom, 2);
        put_le(32'(bits), 2);
        if (fmt_size > FMT_BODY_BYTES) begin
          for (i = 0; i < fmt_size - FMT_BODY_BYTES; i++) wav_image.push_back(pick_byte());
        end
      end
      // without data, a filler chunk keeps the file at or above the minimum
      if (mid_junk || !with_data) put_junk(with_data ? $urandom_range(0, 9) : $urandom_range(24, 48));
      if (with_data && !data_first) put_data(data_declared, data_size);
      for (i = 0; i < trail; i++) wav_image.push_back(8'($urandom));
      stream_len = wav_image.size();
      if (sc == CUT_SHORT) stream_len = $urandom_range(44, wav_image.size() - 1);
      if (sc == SHORT_LENGTH) stream_len = sweep ? 43 : $urandom_range(0, 43);
    end
  endtask

  // stream one file; a zero length makes every byte a file of its own
  task automatic stream_wav(input int unsigned stream_len);
    int unsigned i;
    if (stream_len == 0) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
    end else begin
      for (i = 0; i < stream_len; i++) begin
        send_byte(i < wav_image.size() ? wav_image[i] : 8'($urandom));
      end
    end
  endtask

  // start a file under the largest length, then pull the end in so that the
  // next byte closes it wherever the parser happens to be
  task automatic cut_mid_file(input bit in_signature);
    int unsigned stop;
    int unsigned scratch;
    int unsigned i;
    build_wav(CLEAN_FILE, 1'b0, scratch);
    stop = in_signature ? $urandom_range(1, 11) : $urandom_range(1, wav_image.size() - 1);
    write_length(HugeLength);
    for (i = 0; i < stop; i++) send_byte(wav_image[i]);
    write_length($urandom_range(stop + 1));
    send_byte(wav_image[stop]);
  endtask

  initial begin
    int unsigned round;
    int unsigned stream_len;
    int unsigned cuts;
    scenario_t   sc;
    round = 0;
    cuts  = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // zero-, one- and two-byte lengths: each file fails as too short at its first byte
    write_length(32'd0);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h55);
    send_byte(8'hAA);
    write_length(32'd1);
    send_byte(8'h5A);
    send_byte(8'hA5);
    write_length(32'd2);
    send_byte(8'h0F);
    send_byte(8'hF0);

    // visit every shape once, then favour well-formed files with random content
    while (sent_bytes < ByteTarget) begin
      case (sent_bytes * 4 / ByteTarget)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 50; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 50; end
        default: begin gap_pct = 32; stall_pct = 32; end
      endcase
      if (round < ScenarioCount) sc = scenario_t'(round);
      else if ($urandom_range(1)) sc = CLEAN_FILE;
      else sc = scenario_t'($urandom_range(ScenarioCount - 1));
      build_wav(sc, round < ScenarioCount, stream_len);
      write_length(stream_len);
      // now and then repeat the file at once to show the state clears
      repeat (($urandom_range(2) == 0) ? 2 : 1) stream_wav(stream_len);
      if (round % 7 == 3) begin
        cut_mid_file(cuts == 0);
        cuts++;
      end
      round++;
    end

    settle();
    if (fault_total == 0) begin
      $display("wav_pcm_stream_parser verification clean");
    end else begin
      $display("wav_pcm_stream_parser verification failed");
    end
    $finish;
  end

endmodule
